/* src/hfe_pkg.sv */
// shared types, constants and helper functions of the haar feature evaluator
package hfe_pkg;

    // request command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // feature kind codes
    localparam logic [2:0] KIND_TWO_H   = 3'd0;
    localparam logic [2:0] KIND_TWO_V   = 3'd1;
    localparam logic [2:0] KIND_THREE_H = 3'd2;
    localparam logic [2:0] KIND_THREE_V = 3'd3;
    localparam logic [2:0] KIND_FOUR    = 3'd4;

    // saturation bound of the feature value
    localparam int VALUE_LIMIT = 16711680;
    localparam int VALUE_W     = 25;

    // divide by three through a reciprocal, exact for operands below 2048
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    // term sequencing: up to nine terms, two per read cycle
    localparam int STEP_W = 3;
    localparam int IDX_W  = 4;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [23:0] entry_value;
        logic [8:0]  win_width;
        logic [8:0]  win_height;
        logic [2:0]  feature_kind;
    } hfe_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] feature_value;
        logic                      is_positive;
        logic                      out_of_bounds;
    } hfe_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_GRID,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } hfe_state_t;

    // one corner term: grid row, grid column and its weight
    typedef struct packed {
        logic              valid;
        logic [1:0]        ri;
        logic [1:0]        ci;
        logic signed [3:0] coef;
    } term_t;

    // controller to datapath
    typedef struct packed {
        logic              write_en;
        logic              capture;
        logic              prep;
        logic              grid;
        logic              issue;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } hfe_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_query;
        logic skip;
        logic last_pair;
        logic out_free;
    } hfe_stat_t;

    function automatic logic [8:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'(DIV3_MUL);
        return p[DIV3_SHIFT +: 9];
    endfunction

    function automatic term_t mk_term(input logic [1:0] ri, input logic [1:0] ci,
                                      input logic signed [3:0] coef);
        term_t t;
        t.valid = 1'b1;
        t.ri    = ri;
        t.ci    = ci;
        t.coef  = coef;
        return t;
    endfunction

    // corner terms of each feature over its row and column grid
    function automatic term_t term_at(input logic [2:0] kind, input logic [IDX_W-1:0] idx);
        term_t t;
        t = '0;
        unique case (kind)
            KIND_TWO_H: begin
                case (idx)
                    4'd0: t = mk_term(2'd0, 2'd0, 4'sd1);
                    4'd1: t = mk_term(2'd0, 2'd1, -4'sd2);
                    4'd2: t = mk_term(2'd0, 2'd2, 4'sd1);
                    4'd3: t = mk_term(2'd1, 2'd0, -4'sd1);
                    4'd4: t = mk_term(2'd1, 2'd1, 4'sd2);
                    4'd5: t = mk_term(2'd1, 2'd2, -4'sd1);
                    default: t = '0;
                endcase
            end
            KIND_TWO_V: begin
                case (idx)
                    4'd0: t = mk_term(2'd0, 2'd0, 4'sd1);
                    4'd1: t = mk_term(2'd1, 2'd0, -4'sd2);
                    4'd2: t = mk_term(2'd2, 2'd0, 4'sd1);
                    4'd3: t = mk_term(2'd0, 2'd1, -4'sd1);
                    4'd4: t = mk_term(2'd1, 2'd1, 4'sd2);
                    4'd5: t = mk_term(2'd2, 2'd1, -4'sd1);
                    default: t = '0;
                endcase
            end
            KIND_THREE_H: begin
                case (idx)
                    4'd0: t = mk_term(2'd0, 2'd0, -4'sd1);
                    4'd1: t = mk_term(2'd0, 2'd1, 4'sd2);
                    4'd2: t = mk_term(2'd0, 2'd2, -4'sd2);
                    4'd3: t = mk_term(2'd0, 2'd3, 4'sd1);
                    4'd4: t = mk_term(2'd1, 2'd0, 4'sd1);
                    4'd5: t = mk_term(2'd1, 2'd1, -4'sd2);
                    4'd6: t = mk_term(2'd1, 2'd2, 4'sd2);
                    4'd7: t = mk_term(2'd1, 2'd3, -4'sd1);
                    default: t = '0;
                endcase
            end
            KIND_THREE_V: begin
                case (idx)
                    4'd0: t = mk_term(2'd0, 2'd0, -4'sd1);
                    4'd1: t = mk_term(2'd1, 2'd0, 4'sd2);
                    4'd2: t = mk_term(2'd2, 2'd0, -4'sd2);
                    4'd3: t = mk_term(2'd3, 2'd0, 4'sd1);
                    4'd4: t = mk_term(2'd0, 2'd1, 4'sd1);
                    4'd5: t = mk_term(2'd1, 2'd1, -4'sd2);
                    4'd6: t = mk_term(2'd2, 2'd1, 4'sd2);
                    4'd7: t = mk_term(2'd3, 2'd1, -4'sd1);
                    default: t = '0;
                endcase
            end
            KIND_FOUR: begin
                case (idx)
                    4'd0: t = mk_term(2'd0, 2'd0, -4'sd1);
                    4'd1: t = mk_term(2'd0, 2'd1, 4'sd2);
                    4'd2: t = mk_term(2'd0, 2'd2, -4'sd1);
                    4'd3: t = mk_term(2'd1, 2'd0, 4'sd2);
                    4'd4: t = mk_term(2'd1, 2'd1, -4'sd4);
                    4'd5: t = mk_term(2'd1, 2'd2, 4'sd2);
                    4'd6: t = mk_term(2'd2, 2'd0, -4'sd1);
                    4'd7: t = mk_term(2'd2, 2'd1, 4'sd2);
                    4'd8: t = mk_term(2'd2, 2'd2, -4'sd1);
                    default: t = '0;
                endcase
            end
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

/* src/hfe_mem.sv */
// dual-port integral image memory, one write/read port and one read port
module hfe_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 24
) (
    input  logic              aclk,
    input  logic              a_we,
    input  logic [ADDR_W-1:0] a_addr,
    input  logic [DATA_W-1:0] a_wdata,
    output logic [DATA_W-1:0] a_rdata,
    input  logic [ADDR_W-1:0] b_addr,
    output logic [DATA_W-1:0] b_rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] a_rdata_reg;
    logic [DATA_W-1:0] b_rdata_reg;

    // port a: write, or registered read
    always_ff @(posedge aclk) begin
        if (a_we) begin
            mem_array[a_addr] <= a_wdata;
        end else begin
            a_rdata_reg <= mem_array[a_addr];
        end
    end

    // port b: registered read
    always_ff @(posedge aclk) begin
        b_rdata_reg <= mem_array[b_addr];
    end

    assign a_rdata = a_rdata_reg;
    assign b_rdata = b_rdata_reg;

endmodule

/* src/hfe_ctrl.sv */
// controller state machine that sequences loads and feature queries
module hfe_ctrl
    import hfe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hfe_stat_t stat,
    output hfe_cmd_t  cmd
);

    hfe_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // state and step registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.in_query) state_next = ST_PREP;
            end
            ST_PREP: state_next = ST_GRID;
            ST_GRID: begin
                state_next = stat.skip ? ST_DONE : ST_READ;
            end
            ST_READ: begin
                if (stat.last_pair) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // pair counter
    always_comb begin
        step_next = step_reg;
        unique case (state_reg)
            ST_GRID: step_next = '0;
            ST_READ: step_next = step_reg + STEP_W'(1);
            default: step_next = step_reg;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        cmd.step = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture  = stat.in_query;
                    cmd.write_en = !stat.in_query;
                end
            end
            ST_PREP: cmd.prep = 1'b1;
            ST_GRID: cmd.grid = 1'b1;
            ST_READ: cmd.issue = 1'b1;
            ST_DRAIN: begin
            end
            ST_DONE: cmd.out_load = stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

/* src/hfe_datapath.sv */
// datapath: window grid, corner reads, weighted accumulation and result register
module hfe_datapath
    import hfe_pkg::*;
#(
    parameter int IMG_DIM   = 256,
    parameter int SUM_WIDTH = 24
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  hfe_in_t   s_data,
    input  hfe_cmd_t  cmd,
    output hfe_stat_t stat,
    input  logic      m_ready,
    output logic      m_valid,
    output hfe_out_t  m_data
);

    localparam int DEPTH  = IMG_DIM * IMG_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = SUM_WIDTH + 6;
    localparam int CMP_W  = 40;

    // query fields
    logic [7:0] row_reg, col_reg;
    logic [8:0] w_reg, h_reg;
    logic [2:0] kind_reg;

    // window fractions and bounds flag
    logic [7:0] w_half_reg, h_half_reg;
    logic [8:0] w_third_reg, w_two_third_reg, h_third_reg, h_two_third_reg;
    logic       oob_reg;

    // row and column grid
    logic [7:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [7:0] c0_reg, c1_reg, c2_reg, c3_reg;

    // read pipeline and accumulator
    logic                    pend_reg;
    logic signed [3:0]       coef0_reg, coef1_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // result register
    logic     m_valid_reg;
    hfe_out_t m_data_reg;

    logic [IDX_W-1:0]     idx0, idx1, idx_after;
    term_t                t0, t1;
    logic [ADDR_W-1:0]    addr0, addr1, load_addr;
    logic                 load_in_range, mem_we;
    logic [ADDR_W-1:0]    a_addr;
    logic [SUM_WIDTH-1:0] rd_a, rd_b;
    logic                 oob_now;
    logic signed [CMP_W-1:0] acc_wide, sat_value;
    logic signed [CMP_W-1:0] limit_pos, limit_neg;

    function automatic logic [7:0] back(input logic [7:0] base, input logic [8:0] off);
        logic [8:0] d;
        d = {1'b0, base} - off;
        return d[7:0];
    endfunction

    function automatic logic [7:0] pick(input logic [1:0] sel, input logic [7:0] g0,
                                        input logic [7:0] g1, input logic [7:0] g2,
                                        input logic [7:0] g3);
        logic [7:0] v;
        case (sel)
            2'd0: v = g0;
            2'd1: v = g1;
            2'd2: v = g2;
            default: v = g3;
        endcase
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [7:0] r, input logic [7:0] c);
        return ADDR_W'(32'(r) * 32'(IMG_DIM) + 32'(c));
    endfunction

    function automatic logic signed [ACC_W-1:0] weigh(input logic [SUM_WIDTH-1:0] d,
                                                      input logic signed [3:0] coef);
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] v;
        x = signed'({{(ACC_W - SUM_WIDTH){1'b0}}, d});
        case (coef)
            4'sd1:   v = x;
            -4'sd1:  v = -x;
            4'sd2:   v = x <<< 1;
            -4'sd2:  v = -(x <<< 1);
            -4'sd4:  v = -(x <<< 2);
            default: v = '0;
        endcase
        return v;
    endfunction

    // capture query fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            row_reg  <= s_data.row;
            col_reg  <= s_data.col;
            w_reg    <= s_data.win_width;
            h_reg    <= s_data.win_height;
            kind_reg <= s_data.feature_kind;
        end
    end

    // window fractions and bounds check
    assign oob_now = ({1'b0, row_reg} < h_reg) || ({1'b0, col_reg} < w_reg)
                   || (32'(row_reg) >= IMG_DIM) || (32'(col_reg) >= IMG_DIM);

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            w_half_reg      <= w_reg[8:1];
            h_half_reg      <= h_reg[8:1];
            w_third_reg     <= div3({1'b0, w_reg});
            w_two_third_reg <= div3({w_reg, 1'b0});
            h_third_reg     <= div3({1'b0, h_reg});
            h_two_third_reg <= div3({h_reg, 1'b0});
            oob_reg         <= oob_now;
        end
    end

    // grid lines of the chosen feature
    always_ff @(posedge aclk) begin
        if (cmd.grid) begin
            r0_reg <= row_reg;
            c0_reg <= col_reg;
            case (kind_reg) inside
                KIND_TWO_V, KIND_FOUR: begin
                    r1_reg <= back(row_reg, {1'b0, h_half_reg});
                    r2_reg <= back(row_reg, h_reg);
                    r3_reg <= back(row_reg, h_reg);
                end
                KIND_THREE_V: begin
                    r1_reg <= back(row_reg, h_third_reg);
                    r2_reg <= back(row_reg, h_two_third_reg);
                    r3_reg <= back(row_reg, h_reg);
                end
                default: begin
                    r1_reg <= back(row_reg, h_reg);
                    r2_reg <= back(row_reg, h_reg);
                    r3_reg <= back(row_reg, h_reg);
                end
            endcase
            case (kind_reg) inside
                KIND_TWO_H, KIND_FOUR: begin
                    c1_reg <= back(col_reg, {1'b0, w_half_reg});
                    c2_reg <= back(col_reg, w_reg);
                    c3_reg <= back(col_reg, w_reg);
                end
                KIND_THREE_H: begin
                    c1_reg <= back(col_reg, w_third_reg);
                    c2_reg <= back(col_reg, w_two_third_reg);
                    c3_reg <= back(col_reg, w_reg);
                end
                default: begin
                    c1_reg <= back(col_reg, w_reg);
                    c2_reg <= back(col_reg, w_reg);
                    c3_reg <= back(col_reg, w_reg);
                end
            endcase
        end
    end

    // term pair of the current read step
    assign idx0      = {cmd.step, 1'b0};
    assign idx1      = {cmd.step, 1'b1};
    assign idx_after = idx0 + IDX_W'(2);
    assign t0        = term_at(kind_reg, idx0);
    assign t1        = term_at(kind_reg, idx1);

    assign addr0 = entry_addr(pick(t0.ri, r0_reg, r1_reg, r2_reg, r3_reg),
                              pick(t0.ci, c0_reg, c1_reg, c2_reg, c3_reg));
    assign addr1 = entry_addr(pick(t1.ri, r0_reg, r1_reg, r2_reg, r3_reg),
                              pick(t1.ci, c0_reg, c1_reg, c2_reg, c3_reg));

    // load address and range check
    assign load_addr     = entry_addr(s_data.row, s_data.col);
    assign load_in_range = (32'(s_data.row) < IMG_DIM) && (32'(s_data.col) < IMG_DIM);
    assign mem_we        = cmd.write_en && load_in_range;
    assign a_addr        = mem_we ? load_addr : addr0;

    hfe_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SUM_WIDTH)
    ) u_mem (
        .aclk    (aclk),
        .a_we    (mem_we),
        .a_addr  (a_addr),
        .a_wdata (SUM_WIDTH'(s_data.entry_value)),
        .a_rdata (rd_a),
        .b_addr  (addr1),
        .b_rdata (rd_b)
    );

    // weights travel alongside the memory read
    always_ff @(posedge aclk) begin
        coef0_reg <= t0.valid ? t0.coef : 4'sd0;
        coef1_reg <= t1.valid ? t1.coef : 4'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.issue;
        end
    end

    // accumulate the weighted corner pair
    always_comb begin
        acc_next = acc_reg;
        if (cmd.grid) begin
            acc_next = '0;
        end else if (pend_reg) begin
            acc_next = acc_reg + weigh(rd_a, coef0_reg) + weigh(rd_b, coef1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // saturate to the value range, or force zero for an out-of-bounds query
    assign acc_wide  = {{(CMP_W - ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
    assign limit_pos = CMP_W'(VALUE_LIMIT);
    assign limit_neg = -CMP_W'(VALUE_LIMIT);

    always_comb begin
        sat_value = acc_wide;
        if (oob_reg) begin
            sat_value = '0;
        end else if (acc_wide > limit_pos) begin
            sat_value = limit_pos;
        end else if (acc_wide < limit_neg) begin
            sat_value = limit_neg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.feature_value <= sat_value[VALUE_W-1:0];
            m_data_reg.is_positive   <= (sat_value > CMP_W'(0));
            m_data_reg.out_of_bounds <= oob_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // status to the controller
    assign stat.in_query  = (s_data.cmd == CMD_QUERY);
    assign stat.skip      = oob_reg || !term_at(kind_reg, '0).valid;
    assign stat.last_pair = !term_at(kind_reg, idx_after).valid;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

/* src/haar_feature_eval_core.sv */
// top level of the haar-like feature evaluator over an integral image
//
//  channel | ports                     | carries
//  --------+---------------------------+--------------------------------------
//  input   | s_valid s_ready s_data    | load entry or feature query request
//  result  | m_valid m_ready m_data    | feature value, positive and bounds flags
//
// a load gives no result and the next request is taken right after; a query runs prep,
// grid, P read steps and drain, P the count of corner-read pairs of its kind (3 to 5),
// each read by the two memory ports; bounds failures and unused kinds skip to done
// a finished result waits in the output register while the next request is taken
// reset clears control state only; the image memory is not cleared
module haar_feature_eval_core
    import hfe_pkg::*;
#(
    parameter int IMG_DIM   = 256,
    parameter int SUM_WIDTH = 24
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hfe_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hfe_out_t m_data
);

    hfe_cmd_t  cmd;
    hfe_stat_t stat;

    hfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hfe_datapath #(
        .IMG_DIM   (IMG_DIM),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
